FILE: design/tccf_pkg.sv
// Package for the tilt-compensated compass filter: widths, constants, CORDIC table,
// state types and sequencer step codes. No dependencies.
package tccf_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned VecW        = 56;
  localparam int unsigned AngW        = 25;
  localparam int unsigned OutAngW     = 17;
  localparam int unsigned RadW        = 32;
  localparam int unsigned RootW       = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 48;
  localparam int unsigned StepW       = 5;

  localparam logic signed [AngW-1:0] HALF_TURN       = 25'sd4608000;
  localparam logic signed [VecW-1:0] CORDIC_INV_GAIN = 56'sd652032875;

  localparam logic [CfgIdxW-1:0] CFG_HARD_IRON     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOFT_ROW0     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SOFT_ROW1     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SOFT_ROW2     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TILT_ALPHA    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HEADING_ALPHA = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DECLINATION   = 3'd6;

  localparam logic [StepW-1:0] STEP_ZZ          = 5'd0;
  localparam logic [StepW-1:0] STEP_YY          = 5'd1;
  localparam logic [StepW-1:0] STEP_XX          = 5'd2;
  localparam logic [StepW-1:0] STEP_PITCH_BLEND = 5'd3;
  localparam logic [StepW-1:0] STEP_ROLL_BLEND  = 5'd4;
  localparam logic [StepW-1:0] STEP_M00         = 5'd5;
  localparam logic [StepW-1:0] STEP_M01         = 5'd6;
  localparam logic [StepW-1:0] STEP_M02         = 5'd7;
  localparam logic [StepW-1:0] STEP_M10         = 5'd8;
  localparam logic [StepW-1:0] STEP_M11         = 5'd9;
  localparam logic [StepW-1:0] STEP_M12         = 5'd10;
  localparam logic [StepW-1:0] STEP_M20         = 5'd11;
  localparam logic [StepW-1:0] STEP_M21         = 5'd12;
  localparam logic [StepW-1:0] STEP_M22         = 5'd13;
  localparam logic [StepW-1:0] STEP_SRSP        = 5'd14;
  localparam logic [StepW-1:0] STEP_SRCP        = 5'd15;
  localparam logic [StepW-1:0] STEP_XH0         = 5'd16;
  localparam logic [StepW-1:0] STEP_XH1         = 5'd17;
  localparam logic [StepW-1:0] STEP_YH0         = 5'd18;
  localparam logic [StepW-1:0] STEP_YH1         = 5'd19;
  localparam logic [StepW-1:0] STEP_YH2         = 5'd20;
  localparam logic [StepW-1:0] STEP_HEAD_BLEND  = 5'd21;

  typedef enum logic [1:0] {CORD_IDLE, CORD_NORM, CORD_ITER, CORD_DONE} cord_state_e;
  typedef enum logic [1:0] {SQRT_IDLE, SQRT_RUN, SQRT_DONE} sqrt_state_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_ACC,
    ST_SQRT_P_GO, ST_SQRT_P_WAIT, ST_ATAN_P_GO, ST_ATAN_P_WAIT,
    ST_SQRT_R_GO, ST_SQRT_R_WAIT, ST_ATAN_R_GO, ST_ATAN_R_WAIT,
    ST_SC_P_GO, ST_SC_P_WAIT, ST_SC_R_GO, ST_SC_R_WAIT,
    ST_ATAN_H_GO, ST_ATAN_H_WAIT, ST_HEAD, ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cord_ctl_t;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [3:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      4'd0:    v = 25'sd1152000;
      4'd1:    v = 25'sd680065;
      4'd2:    v = 25'sd359328;
      4'd3:    v = 25'sd182400;
      4'd4:    v = 25'sd91554;
      4'd5:    v = 25'sd45822;
      4'd6:    v = 25'sd22916;
      4'd7:    v = 25'sd11459;
      4'd8:    v = 25'sd5730;
      4'd9:    v = 25'sd2865;
      4'd10:   v = 25'sd1432;
      4'd11:   v = 25'sd716;
      4'd12:   v = 25'sd358;
      4'd13:   v = 25'sd179;
      4'd14:   v = 25'sd90;
      default: v = 25'sd45;
    endcase
    return v;
  endfunction

endpackage

FILE: design/tccf_if.sv
// Handshake channels of the compass filter: sample input, result output and
// register write port. No dependencies.
interface tccf_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;
  modport source (output valid, operation, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, operation, sample_x, sample_y, sample_z, output ready);
endinterface

interface tccf_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch_out;
  logic signed [14:0] roll_out;
  logic        [15:0] heading_out;
  modport source (output valid, pitch_out, roll_out, heading_out, input ready);
  modport sink   (input valid, pitch_out, roll_out, heading_out, output ready);
endinterface

interface tccf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/tccf_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on tccf_pkg.
module tccf_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tccf_pkg::RadW-1:0]   rad_i,
  output logic                        done_o,
  output logic [tccf_pkg::RootW-1:0]  root_o
);
  import tccf_pkg::*;

  sqrt_state_e     state_q, state_d;
  logic [RadW-1:0] n_q, n_d;
  logic [RadW:0]   r_q, r_d;
  logic [RadW-1:0] bit_q, bit_d;
  logic [RadW:0]   trial;

  assign trial = r_q + {1'b0, bit_q};

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    r_d     = r_q;
    bit_d   = bit_q;
    case (state_q)
      SQRT_IDLE: begin
        if (start_i) begin
          n_d     = rad_i;
          r_d     = '0;
          bit_d   = RadW'(1) << (RadW - 2);
          state_d = SQRT_RUN;
        end
      end
      SQRT_RUN: begin
        if ({1'b0, n_q} >= trial) begin
          n_d = n_q - trial[RadW-1:0];
          r_d = (r_q >> 1) + {1'b0, bit_q};
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = SQRT_DONE;
        end
      end
      SQRT_DONE: state_d = SQRT_IDLE;
      default:   state_d = SQRT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQRT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = (state_q == SQRT_DONE);
  assign root_o = r_q[RootW-1:0];

endmodule

FILE: design/tccf_cordic.sv
// Shared iterative CORDIC: vectoring (atan2 with normalizing shifts) and
// rotation (cos/sin in Q15). Depends on tccf_pkg.
module tccf_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tccf_pkg::cord_ctl_t                  ctl_i,
  input  logic signed [tccf_pkg::VecW-1:0]     x_i,
  input  logic signed [tccf_pkg::VecW-1:0]     y_i,
  input  logic signed [tccf_pkg::AngW-1:0]     z_i,
  output logic                                 done_o,
  output logic signed [tccf_pkg::OutAngW-1:0]  angle_o,
  output logic signed [tccf_pkg::OutAngW-1:0]  cos_o,
  output logic signed [tccf_pkg::OutAngW-1:0]  sin_o
);
  import tccf_pkg::*;

  localparam logic [VecW-2:0] NormHigh = (VecW-1)'(1) << 30;
  localparam logic [VecW-2:0] NormLow  = (VecW-1)'(1) << 29;

  cord_state_e            state_q, state_d;
  logic signed [VecW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0] z_q, z_d;
  logic [VecW-2:0]        m_q, m_d;
  logic [3:0]             it_q, it_d;
  logic                   vec_q, vec_d;
  logic signed [VecW-1:0] ax, ay, dx, dy;
  logic                   sub;

  assign ax  = x_i[VecW-1] ? -x_i : x_i;
  assign ay  = y_i[VecW-1] ? -y_i : y_i;
  assign dx  = y_q >>> it_q;
  assign dy  = x_q >>> it_q;
  assign sub = vec_q ? y_q[VecW-1] : !z_q[AngW-1];

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    m_d     = m_q;
    it_d    = it_q;
    vec_d   = vec_q;
    case (state_q)
      CORD_IDLE: begin
        if (ctl_i.start) begin
          vec_d = ctl_i.vectoring;
          it_d  = '0;
          if (ctl_i.vectoring) begin
            x_d = x_i;
            y_d = y_i;
            z_d = '0;
            m_d = (ax > ay) ? ax[VecW-2:0] : ay[VecW-2:0];
            if (x_i == '0 && y_i == '0) begin
              state_d = CORD_DONE;
            end else begin
              state_d = CORD_NORM;
            end
          end else begin
            x_d     = CORDIC_INV_GAIN;
            y_d     = '0;
            z_d     = z_i;
            state_d = CORD_ITER;
          end
        end
      end
      CORD_NORM: begin
        if (m_q >= NormHigh) begin
          x_d = x_q >>> 1;
          y_d = y_q >>> 1;
          m_d = m_q >> 1;
        end else if (m_q < NormLow) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
          m_d = m_q << 1;
        end else begin
          if (x_q[VecW-1]) begin
            z_d = y_q[VecW-1] ? -HALF_TURN : HALF_TURN;
            x_d = -x_q;
            y_d = -y_q;
          end
          state_d = CORD_ITER;
        end
      end
      CORD_ITER: begin
        if (sub) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_lut(it_q);
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_lut(it_q);
        end
        it_d = it_q + 4'd1;
        if (it_q == 4'(CordicSteps - 1)) begin
          state_d = CORD_DONE;
        end
      end
      CORD_DONE: state_d = CORD_IDLE;
      default:   state_d = CORD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    m_q   <= m_d;
    it_q  <= it_d;
    vec_q <= vec_d;
  end

  assign done_o  = (state_q == CORD_DONE);
  assign angle_o = OutAngW'((z_q + AngW'(128)) >>> 8);
  assign cos_o   = OutAngW'(x_q >>> 15);
  assign sin_o   = OutAngW'(y_q >>> 15);

endmodule

FILE: design/tilt_compensated_compass_filter_unit.sv
// Tilt-compensated compass filter: sequencer around one shared multiplier, a CORDIC and a sqrt.
// Accelerometer items run two square roots and two atan2 passes, magnetometer items seventeen
// products, two sin/cos passes and one atan2; the atan2 normalizing shifts vary the latency.
// One item at a time; the next is accepted in the cycle after the result is registered. Reset
// clears filter state to zero and loads the identity calibration.
module tilt_compensated_compass_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tccf_in_if.sink     sample_i,
  tccf_out_if.source  result_o,
  tccf_cfg_if.sink    cfg_i
);
  import tccf_pkg::*;

  logic [CfgDataW-1:0] hard_q, row0_q, row1_q, row2_q;
  logic [15:0]         talpha_q, halpha_q;
  logic signed [15:0]  decl_q;

  ctrl_state_e        state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;

  logic signed [15:0] sx_q, sy_q, sz_q;
  logic signed [53:0] prod_q;
  logic signed [55:0] acc_q, acc_sum, xh_q;
  logic [RadW-1:0]    sq1_q, sq2_q;
  logic signed [34:0] mv0_q, mv1_q, mv2_q;
  logic signed [16:0] cp_q, sp_q, cr_q, sr_q;
  logic signed [17:0] srsp_q, srcp_q;
  logic signed [14:0] p_q, r_q, fp_q, fr_q;
  logic [15:0]        fh_q, hd_q;
  logic               out_valid_q, load_out, accept;
  logic signed [14:0] out_p_q, out_r_q;
  logic [15:0]        out_h_q;

  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [16:0] hx, hy, hz;
  logic signed [17:0] blend_inc, head_raw, head_wrap, diff_raw, diff, fh_raw, tilt_neg;

  cord_ctl_t                  cord_ctl;
  logic signed [VecW-1:0]     cord_x, cord_y;
  logic signed [AngW-1:0]     cord_z;
  logic                       cord_done;
  logic signed [OutAngW-1:0]  cord_angle, cord_cos, cord_sin;
  logic                       sqrt_start, sqrt_done;
  logic [RadW-1:0]            sqrt_rad;
  logic [RootW-1:0]           sqrt_root;

  function automatic logic signed [15:0] lane(input logic [CfgDataW-1:0] r,
                                              input logic [1:0] k);
    return $signed(r[16*k +: 16]);
  endfunction

  function automatic logic signed [14:0] clamp_tilt(input logic signed [17:0] v);
    logic signed [14:0] c;
    if (v > 18'sd9000) begin
      c = 15'sd9000;
    end else if (v < -18'sd9000) begin
      c = -15'sd9000;
    end else begin
      c = 15'(v);
    end
    return c;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_q   <= '0;
      row0_q   <= 48'd8192;
      row1_q   <= 48'd8192 << 16;
      row2_q   <= 48'd8192 << 32;
      talpha_q <= 16'd6554;
      halpha_q <= 16'd6554;
      decl_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HARD_IRON:     hard_q   <= cfg_i.data;
        CFG_SOFT_ROW0:     row0_q   <= cfg_i.data;
        CFG_SOFT_ROW1:     row1_q   <= cfg_i.data;
        CFG_SOFT_ROW2:     row2_q   <= cfg_i.data;
        CFG_TILT_ALPHA:    talpha_q <= cfg_i.data[15:0];
        CFG_HEADING_ALPHA: halpha_q <= cfg_i.data[15:0];
        CFG_DECLINATION:   decl_q   <= $signed(cfg_i.data[15:0]);
        default: ;
      endcase
    end
  end

  assign accept         = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == ST_IDLE);

  assign hx = 17'(sx_q) - 17'(lane(hard_q, 2'd0));
  assign hy = 17'(sy_q) - 17'(lane(hard_q, 2'd1));
  assign hz = 17'(sz_q) - 17'(lane(hard_q, 2'd2));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      STEP_ZZ:          begin mul_a = 36'(sz_q); mul_b = 18'(sz_q); end
      STEP_YY:          begin mul_a = 36'(sy_q); mul_b = 18'(sy_q); end
      STEP_XX:          begin mul_a = 36'(sx_q); mul_b = 18'(sx_q); end
      STEP_PITCH_BLEND: begin
        mul_a = 36'(p_q) - 36'(fp_q);
        mul_b = $signed({2'b00, talpha_q});
      end
      STEP_ROLL_BLEND:  begin
        mul_a = 36'(r_q) - 36'(fr_q);
        mul_b = $signed({2'b00, talpha_q});
      end
      STEP_M00:         begin mul_a = 36'(hx); mul_b = 18'(lane(row0_q, 2'd0)); end
      STEP_M01:         begin mul_a = 36'(hy); mul_b = 18'(lane(row0_q, 2'd1)); end
      STEP_M02:         begin mul_a = 36'(hz); mul_b = 18'(lane(row0_q, 2'd2)); end
      STEP_M10:         begin mul_a = 36'(hx); mul_b = 18'(lane(row1_q, 2'd0)); end
      STEP_M11:         begin mul_a = 36'(hy); mul_b = 18'(lane(row1_q, 2'd1)); end
      STEP_M12:         begin mul_a = 36'(hz); mul_b = 18'(lane(row1_q, 2'd2)); end
      STEP_M20:         begin mul_a = 36'(hx); mul_b = 18'(lane(row2_q, 2'd0)); end
      STEP_M21:         begin mul_a = 36'(hy); mul_b = 18'(lane(row2_q, 2'd1)); end
      STEP_M22:         begin mul_a = 36'(hz); mul_b = 18'(lane(row2_q, 2'd2)); end
      STEP_SRSP:        begin mul_a = 36'(sr_q); mul_b = 18'(sp_q); end
      STEP_SRCP:        begin mul_a = 36'(sr_q); mul_b = 18'(cp_q); end
      STEP_XH0:         begin mul_a = 36'(mv0_q); mul_b = 18'(cp_q); end
      STEP_XH1:         begin mul_a = 36'(mv2_q); mul_b = 18'(sp_q); end
      STEP_YH0:         begin mul_a = 36'(mv0_q); mul_b = srsp_q; end
      STEP_YH1:         begin mul_a = 36'(mv1_q); mul_b = 18'(cr_q); end
      STEP_YH2:         begin mul_a = 36'(mv2_q); mul_b = srcp_q; end
      STEP_HEAD_BLEND:  begin mul_a = 36'(diff); mul_b = $signed({2'b00, halpha_q}); end
      default: ;
    endcase
  end

  assign acc_sum   = acc_q + 56'(prod_q);
  assign blend_inc = 18'((prod_q + 54'sd32768) >>> 16);
  assign tilt_neg  = 18'sd0 - 18'(cord_angle);

  always_comb begin
    head_raw = 18'sd0 - 18'(cord_angle) - 18'sd9000 + 18'(decl_q);
    if (head_raw < -18'sd36000) begin
      head_wrap = head_raw + 18'sd72000;
    end else if (head_raw < 18'sd0) begin
      head_wrap = head_raw + 18'sd36000;
    end else if (head_raw >= 18'sd36000) begin
      head_wrap = head_raw - 18'sd36000;
    end else begin
      head_wrap = head_raw;
    end
    diff_raw = $signed({2'b00, hd_q}) - $signed({2'b00, fh_q});
    if (diff_raw > 18'sd18000) begin
      diff = diff_raw - 18'sd36000;
    end else if (diff_raw < -18'sd18000) begin
      diff = diff_raw + 18'sd36000;
    end else begin
      diff = diff_raw;
    end
    fh_raw = $signed({2'b00, fh_q}) + blend_inc;
    if (fh_raw < 18'sd0) begin
      fh_raw = fh_raw + 18'sd36000;
    end else if (fh_raw >= 18'sd36000) begin
      fh_raw = fh_raw - 18'sd36000;
    end
  end

  always_comb begin
    state_d            = state_q;
    step_d             = step_q;
    cord_ctl.start     = 1'b0;
    cord_ctl.vectoring = 1'b1;
    cord_x             = '0;
    cord_y             = '0;
    cord_z             = '0;
    sqrt_start         = 1'b0;
    sqrt_rad           = sq1_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MUL;
          step_d  = sample_i.operation ? STEP_M00 : STEP_ZZ;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        case (step_q)
          STEP_XX:         state_d = ST_SQRT_P_GO;
          STEP_ROLL_BLEND: state_d = ST_DONE;
          STEP_HEAD_BLEND: state_d = ST_DONE;
          STEP_M22:        state_d = ST_SC_P_GO;
          STEP_YH2:        state_d = ST_ATAN_H_GO;
          default: begin
            step_d  = step_q + StepW'(1);
            state_d = ST_MUL;
          end
        endcase
      end
      ST_SQRT_P_GO: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT_P_WAIT;
      end
      ST_SQRT_P_WAIT: if (sqrt_done) state_d = ST_ATAN_P_GO;
      ST_ATAN_P_GO: begin
        cord_ctl.start = 1'b1;
        cord_x         = VecW'($signed({1'b0, sqrt_root}));
        cord_y         = VecW'(sx_q);
        state_d        = ST_ATAN_P_WAIT;
      end
      ST_ATAN_P_WAIT: if (cord_done) state_d = ST_SQRT_R_GO;
      ST_SQRT_R_GO: begin
        sqrt_start = 1'b1;
        sqrt_rad   = sq2_q;
        state_d    = ST_SQRT_R_WAIT;
      end
      ST_SQRT_R_WAIT: if (sqrt_done) state_d = ST_ATAN_R_GO;
      ST_ATAN_R_GO: begin
        cord_ctl.start = 1'b1;
        cord_x         = VecW'($signed({1'b0, sqrt_root}));
        cord_y         = VecW'(sy_q);
        state_d        = ST_ATAN_R_WAIT;
      end
      ST_ATAN_R_WAIT: begin
        if (cord_done) begin
          step_d  = STEP_PITCH_BLEND;
          state_d = ST_MUL;
        end
      end
      ST_SC_P_GO: begin
        cord_ctl.start     = 1'b1;
        cord_ctl.vectoring = 1'b0;
        cord_z             = AngW'(fp_q) <<< 8;
        state_d            = ST_SC_P_WAIT;
      end
      ST_SC_P_WAIT: if (cord_done) state_d = ST_SC_R_GO;
      ST_SC_R_GO: begin
        cord_ctl.start     = 1'b1;
        cord_ctl.vectoring = 1'b0;
        cord_z             = AngW'(fr_q) <<< 8;
        state_d            = ST_SC_R_WAIT;
      end
      ST_SC_R_WAIT: begin
        if (cord_done) begin
          step_d  = STEP_SRSP;
          state_d = ST_MUL;
        end
      end
      ST_ATAN_H_GO: begin
        cord_ctl.start = 1'b1;
        cord_x         = acc_q;
        cord_y         = xh_q;
        state_d        = ST_ATAN_H_WAIT;
      end
      ST_ATAN_H_WAIT: if (cord_done) state_d = ST_HEAD;
      ST_HEAD: begin
        step_d  = STEP_HEAD_BLEND;
        state_d = ST_MUL;
      end
      ST_DONE: if (!out_valid_q || result_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_ZZ;
      out_valid_q <= 1'b0;
      fp_q        <= '0;
      fr_q        <= '0;
      fh_q        <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= load_out || (out_valid_q && !result_o.ready);
      if (state_q == ST_ACC) begin
        case (step_q)
          STEP_PITCH_BLEND: fp_q <= clamp_tilt(18'(fp_q) + blend_inc);
          STEP_ROLL_BLEND:  fr_q <= clamp_tilt(18'(fr_q) + blend_inc);
          STEP_HEAD_BLEND:  fh_q <= 16'(fh_raw);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q <= sample_i.sample_x;
      sy_q <= sample_i.sample_y;
      sz_q <= sample_i.sample_z;
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == ST_ACC) begin
      case (step_q)
        STEP_ZZ:  acc_q  <= 56'(prod_q);
        STEP_YY:  sq1_q  <= RadW'(acc_sum);
        STEP_XX:  sq2_q  <= RadW'(acc_sum);
        STEP_M00: acc_q  <= 56'(prod_q);
        STEP_M01: acc_q  <= acc_sum;
        STEP_M02: mv0_q  <= 35'(acc_sum);
        STEP_M10: acc_q  <= 56'(prod_q);
        STEP_M11: acc_q  <= acc_sum;
        STEP_M12: mv1_q  <= 35'(acc_sum);
        STEP_M20: acc_q  <= 56'(prod_q);
        STEP_M21: acc_q  <= acc_sum;
        STEP_M22: mv2_q  <= 35'(acc_sum);
        STEP_SRSP: srsp_q <= 18'(prod_q >>> 15);
        STEP_SRCP: srcp_q <= 18'(prod_q >>> 15);
        STEP_XH0: acc_q  <= 56'(prod_q);
        STEP_XH1: xh_q   <= acc_sum;
        STEP_YH0: acc_q  <= 56'(prod_q);
        STEP_YH1: acc_q  <= acc_sum;
        STEP_YH2: acc_q  <= acc_q - 56'(prod_q);
        default: ;
      endcase
    end
    if (state_q == ST_ATAN_P_WAIT && cord_done) begin
      p_q <= clamp_tilt(tilt_neg);
    end
    if (state_q == ST_ATAN_R_WAIT && cord_done) begin
      r_q <= clamp_tilt(tilt_neg);
    end
    if (state_q == ST_SC_P_WAIT && cord_done) begin
      cp_q <= cord_cos;
      sp_q <= cord_sin;
    end
    if (state_q == ST_SC_R_WAIT && cord_done) begin
      cr_q <= cord_cos;
      sr_q <= cord_sin;
    end
    if (state_q == ST_HEAD) begin
      hd_q <= 16'(head_wrap);
    end
    if (load_out) begin
      out_p_q <= fp_q;
      out_r_q <= fr_q;
      out_h_q <= fh_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.pitch_out   = out_p_q;
  assign result_o.roll_out    = out_r_q;
  assign result_o.heading_out = out_h_q;

  tccf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cord_ctl),
    .x_i     (cord_x),
    .y_i     (cord_y),
    .z_i     (cord_z),
    .done_o  (cord_done),
    .angle_o (cord_angle),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  tccf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_MUL)
    else $error("accepted transfer did not start the sequencer");

  a_tilt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fp_q >= -15'sd9000 && fp_q <= 15'sd9000 && fr_q >= -15'sd9000 && fr_q <= 15'sd9000)
    else $error("filtered tilt out of range");

  a_heading_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fh_q < 16'd36000)
    else $error("filtered heading out of range");

  a_result_posted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished item not posted to the output register");

endmodule
